@@ rtl/csc_pkg.sv @@
package csc_pkg;

  localparam int DIST_W   = 16;
  localparam int MAT_W    = 8;
  localparam int CROSS_W  = 2;
  localparam int HEIGHT_W = 32;
  localparam int VOX_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_MATERIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_ROW        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ROW       = 2'd3;

  localparam logic [VOX_W-1:0]        VOXEL_SIZE_RST = 16'd256;
  localparam logic [MAT_W-1:0]        BRUSH_MAT_RST  = 8'd0;
  localparam logic signed [CFG_W-1:0] LOW_ROW_RST    = 16'sd0;
  localparam logic signed [CFG_W-1:0] HIGH_ROW_RST   = 16'sd63;

  localparam logic [CROSS_W-1:0] CROSS_NONE = 2'd0;
  localparam logic [CROSS_W-1:0] CROSS_ONE  = 2'd1;
  localparam logic [CROSS_W-1:0] CROSS_MAX  = 2'd2;

  localparam logic [MAT_W-1:0] MAT_CARVE = 8'd0;

  // one finished column, handed from the sample front end to the height unit
  typedef struct packed {
    logic                 single_valued;
    logic [CROSS_W-1:0]   crossing_count;
    logic [MAT_W-1:0]     material;
    logic                 interp;
    logic                 top_solid;
    logic [DIST_W-1:0]    num;
    logic [DIST_W-1:0]    span;
  } csc_col_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_OUT
  } csc_state_t;

endpackage

@@ rtl/csc_if.sv @@
interface csc_in_if import csc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] stored_distance;
  logic [MAT_W-1:0]         stored_material;
  logic signed [DIST_W-1:0] brush_depth;
  logic                     column_end;

  modport source (output valid, stored_distance, stored_material, brush_depth, column_end,
                  input ready);
  modport sink (input valid, stored_distance, stored_material, brush_depth, column_end,
                output ready);
endinterface

interface csc_out_if import csc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       single_valued;
  logic signed [HEIGHT_W-1:0] surface_height;
  logic [MAT_W-1:0]           surface_material;
  logic [CROSS_W-1:0]         crossing_count;

  modport source (output valid, single_valued, surface_height, surface_material,
                  crossing_count, input ready);
  modport sink (input valid, single_valued, surface_height, surface_material,
                crossing_count, output ready);
endinterface

@@ rtl/column_surface_classifier_core.sv @@
// results: the column-end sample queues the column; an interpolated surface runs the
// serial divider before the multiply, other surfaces skip it
// throughput: one sample request per cycle while the queue is not full; the height unit
// (serial divider, one multiply, saturation) works on one column at a time, others queue
// reset: config registers return to defaults, the queue empties, the next sample opens a column
module column_surface_classifier_core import csc_pkg::*; #(
  parameter int FRAC_BITS   = 8,
  parameter int ROW_BITS    = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  csc_in_if.sink               in_chan,
  csc_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int QW = $bits(csc_col_t) + ROW_BITS;

  logic [VOX_W-1:0]        voxel_size_r;
  logic [MAT_W-1:0]        brush_mat_r;
  logic signed [CFG_W-1:0] low_row_r;
  logic signed [CFG_W-1:0] high_row_r;

  logic                       q_push, q_pop, q_full, q_empty;
  csc_col_t                   push_col, pop_col;
  logic signed [ROW_BITS-1:0] push_row, pop_row;
  logic [QW-1:0]              pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voxel_size_r <= VOXEL_SIZE_RST;
      brush_mat_r  <= BRUSH_MAT_RST;
      low_row_r    <= LOW_ROW_RST;
      high_row_r   <= HIGH_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOXEL_SIZE:     voxel_size_r <= cfg_data;
        CFG_BRUSH_MATERIAL: brush_mat_r  <= cfg_data[MAT_W-1:0];
        CFG_LOW_ROW:        low_row_r    <= cfg_data;
        CFG_HIGH_ROW:       high_row_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  csc_front #(
    .ROW_BITS (ROW_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_chan            (in_chan),
    .cfg_brush_material (brush_mat_r),
    .cfg_low_row        (low_row_r),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_col              (push_col),
    .q_row              (push_row)
  );

  csc_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_col, push_row}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  assign pop_col = csc_col_t'(pop_data[QW-1:ROW_BITS]);
  assign pop_row = signed'(pop_data[ROW_BITS-1:0]);

  csc_back #(
    .FRAC_BITS (FRAC_BITS),
    .ROW_BITS  (ROW_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_voxel_size (voxel_size_r),
    .cfg_low_row    (low_row_r),
    .cfg_high_row   (high_row_r),
    .q_empty        (q_empty),
    .q_col          (pop_col),
    .q_row          (pop_row),
    .q_pop          (q_pop),
    .out_chan       (out_chan)
  );

endmodule

@@ rtl/csc_fifo.sv @@
module csc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/csc_front.sv @@
module csc_front import csc_pkg::*; #(
  parameter int ROW_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  csc_in_if.sink                    in_chan,
  input  logic [MAT_W-1:0]          cfg_brush_material,
  input  logic signed [CFG_W-1:0]   cfg_low_row,
  input  logic                      q_full,
  output logic                      q_push,
  output csc_col_t                  q_col,
  output logic signed [ROW_BITS-1:0] q_row
);

  logic signed [DIST_W-1:0]   prev_dist_r, prev_dist_nxt;
  logic [MAT_W-1:0]           prev_mat_r, prev_mat_nxt;
  logic                       prev_solid_r, prev_solid_nxt;
  logic [CROSS_W-1:0]         cross_r, cross_nxt;
  logic signed [ROW_BITS-1:0] row_r, row_nxt;
  logic                       first_r, first_nxt;
  logic [MAT_W-1:0]           held_mat_r, held_mat_nxt;
  logic                       job_valid_r, job_valid_nxt;
  logic signed [ROW_BITS-1:0] job_row_r, job_row_nxt;
  logic [DIST_W-1:0]          job_num_r, job_num_nxt;
  logic [DIST_W-1:0]          job_span_r, job_span_nxt;

  logic                       accept;
  logic signed [DIST_W-1:0]   dist_ed;
  logic signed [DIST_W-1:0]   neg_depth;
  logic [MAT_W-1:0]           mat_ed;
  logic                       solid;
  logic signed [DIST_W:0]     span_full;
  logic signed [DIST_W:0]     num_full;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // brush edit
  always_comb begin
    dist_ed   = in_chan.stored_distance;
    mat_ed    = in_chan.stored_material;
    neg_depth = -in_chan.brush_depth;
    if (cfg_brush_material == MAT_CARVE) begin
      if (in_chan.brush_depth > in_chan.stored_distance) begin
        dist_ed = in_chan.brush_depth;
      end
    end else if (in_chan.brush_depth > 16'sd0) begin
      if (neg_depth < in_chan.stored_distance) begin
        dist_ed = neg_depth;
      end
      mat_ed = cfg_brush_material;
    end
    solid = (dist_ed <= 16'sd0);
  end

  assign span_full = (DIST_W + 1)'(dist_ed) - (DIST_W + 1)'(prev_dist_r);
  assign num_full  = -(DIST_W + 1)'(prev_dist_r);

  always_comb begin
    prev_dist_nxt  = prev_dist_r;
    prev_mat_nxt   = prev_mat_r;
    prev_solid_nxt = prev_solid_r;
    cross_nxt      = cross_r;
    row_nxt        = row_r;
    first_nxt      = first_r;
    held_mat_nxt   = held_mat_r;
    job_valid_nxt  = job_valid_r;
    job_row_nxt    = job_row_r;
    job_num_nxt    = job_num_r;
    job_span_nxt   = job_span_r;
    if (accept) begin
      if (first_r) begin
        row_nxt       = ROW_BITS'(cfg_low_row);
        cross_nxt     = CROSS_NONE;
        held_mat_nxt  = mat_ed;
        job_valid_nxt = 1'b0;
      end else begin
        row_nxt = row_r + 1'b1;
        if (solid != prev_solid_r) begin
          // first ground-to-air crossing: hand the interpolation to the back end
          if (cross_r == CROSS_NONE && prev_solid_r) begin
            job_valid_nxt = 1'b1;
            job_row_nxt   = row_r;
            job_num_nxt   = num_full[DIST_W-1:0];
            job_span_nxt  = span_full[DIST_W-1:0];
            held_mat_nxt  = prev_mat_r;
          end
          if (cross_r != CROSS_MAX) begin
            cross_nxt = cross_r + 1'b1;
          end
        end
      end
      prev_dist_nxt  = dist_ed;
      prev_mat_nxt   = mat_ed;
      prev_solid_nxt = solid;
      first_nxt      = in_chan.column_end;
    end
  end

  assign q_push              = accept && in_chan.column_end;
  assign q_col.single_valued = (cross_nxt == CROSS_NONE) || (cross_nxt == CROSS_ONE && !solid);
  assign q_col.crossing_count = cross_nxt;
  assign q_col.material      = held_mat_nxt;
  assign q_col.interp        = job_valid_nxt;
  assign q_col.top_solid     = solid;
  assign q_col.num           = job_num_nxt;
  assign q_col.span          = job_span_nxt;
  assign q_row               = job_row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r      <= 1'b1;
      cross_r      <= CROSS_NONE;
      prev_solid_r <= 1'b0;
      job_valid_r  <= 1'b0;
    end else begin
      first_r      <= first_nxt;
      cross_r      <= cross_nxt;
      prev_solid_r <= prev_solid_nxt;
      job_valid_r  <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_dist_r <= prev_dist_nxt;
    prev_mat_r  <= prev_mat_nxt;
    row_r       <= row_nxt;
    held_mat_r  <= held_mat_nxt;
    job_row_r   <= job_row_nxt;
    job_num_r   <= job_num_nxt;
    job_span_r  <= job_span_nxt;
  end

endmodule

@@ rtl/csc_back.sv @@
module csc_back import csc_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int ROW_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [VOX_W-1:0]           cfg_voxel_size,
  input  logic signed [CFG_W-1:0]    cfg_low_row,
  input  logic signed [CFG_W-1:0]    cfg_high_row,
  input  logic                       q_empty,
  input  csc_col_t                   q_col,
  input  logic signed [ROW_BITS-1:0] q_row,
  output logic                       q_pop,
  csc_out_if.source                  out_chan
);

  localparam int RW    = (ROW_BITS > CFG_W + 1) ? ROW_BITS : CFG_W + 1;
  localparam int AW    = RW + FRAC_BITS;
  localparam int PW    = AW + VOX_W + 1;
  localparam int CNT_W = $clog2(FRAC_BITS);

  csc_state_t               state_r, state_nxt;
  logic signed [RW-1:0]     base_r, base_nxt;
  logic [FRAC_BITS-1:0]     q_r, q_nxt;
  logic [DIST_W:0]          rem_r, rem_nxt;
  logic [DIST_W-1:0]        span_r, span_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic                     single_r, single_nxt;
  logic signed [HEIGHT_W-1:0] height_r, height_nxt;
  logic [MAT_W-1:0]         mat_r, mat_nxt;
  logic [CROSS_W-1:0]       cross_r, cross_nxt;

  logic [DIST_W:0]          rem_dbl;
  logic signed [PW-1:0]     shifted;

  assign rem_dbl = {rem_r[DIST_W-1:0], 1'b0};
  assign shifted = prod_r >>> FRAC_BITS;

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    span_nxt   = span_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    single_nxt = single_r;
    height_nxt = height_r;
    mat_nxt    = mat_r;
    cross_nxt  = cross_r;
    q_pop      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          single_nxt = q_col.single_valued;
          mat_nxt    = q_col.material;
          cross_nxt  = q_col.crossing_count;
          span_nxt   = q_col.span;
          rem_nxt    = {1'b0, q_col.num};
          q_nxt      = '0;
          cnt_nxt    = CNT_W'(FRAC_BITS - 1);
          if (q_col.interp) begin
            base_nxt  = RW'(q_row);
            state_nxt = ST_DIV;
          end else begin
            if (q_col.crossing_count != CROSS_NONE) begin
              base_nxt = '0;
            end else if (q_col.top_solid) begin
              base_nxt = RW'(cfg_high_row) + 1'b1;
            end else begin
              base_nxt = RW'(cfg_low_row);
            end
            state_nxt = ST_MUL;
          end
        end
      end
      // one quotient bit per cycle
      ST_DIV: begin
        if (rem_dbl >= {1'b0, span_r}) begin
          rem_nxt = rem_dbl - {1'b0, span_r};
          q_nxt   = {q_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl;
          q_nxt   = {q_r[FRAC_BITS-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MUL: begin
        prod_nxt  = $signed({base_r, q_r}) * $signed({1'b0, cfg_voxel_size});
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (!shifted[PW-1] && (|shifted[PW-2:HEIGHT_W-1])) begin
          height_nxt = {1'b0, {(HEIGHT_W - 1){1'b1}}};
        end else if (shifted[PW-1] && !(&shifted[PW-2:HEIGHT_W-1])) begin
          height_nxt = {1'b1, {(HEIGHT_W - 1){1'b0}}};
        end else begin
          height_nxt = shifted[HEIGHT_W-1:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    span_r   <= span_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    single_r <= single_nxt;
    height_r <= height_nxt;
    mat_r    <= mat_nxt;
    cross_r  <= cross_nxt;
  end

  assign out_chan.valid            = (state_r == ST_OUT);
  assign out_chan.single_valued    = single_r;
  assign out_chan.surface_height   = height_r;
  assign out_chan.surface_material = mat_r;
  assign out_chan.crossing_count   = cross_r;

endmodule

@@ verif/tb_column_surface_classifier_core.sv @@
module tb_column_surface_classifier_core;
  import csc_pkg::*;

  localparam int FRAC          = 8;
  localparam int TOTAL_SAMPLES = 1050;
  localparam int PHASE_SAMPLES = 80;
  localparam int SETTLE_CYCLES = FRAC + 12;
  localparam int IDLE_LIMIT    = 2000;

  typedef struct {
    logic               single_valued;
    logic signed [31:0] height;
    logic [MAT_W-1:0]   material;
    logic [CROSS_W-1:0] crossings;
  } column_result_t;

  class column_tracker;
    column_result_t expected_columns[$];
    int     errors;
    longint voxel_size;
    longint brush_material;
    longint low_row;
    longint high_row;
    longint prev_dist;
    longint prev_mat;
    bit     prev_solid;
    int     crossings;
    longint cur_row;
    bit     first;
    longint held_height;
    longint held_mat;

    function new();
      errors = 0;
      voxel_size = VOXEL_SIZE_RST;
      brush_material = BRUSH_MAT_RST;
      low_row = LOW_ROW_RST;
      high_row = HIGH_ROW_RST;
      prev_dist = 0;
      prev_mat = 0;
      prev_solid = 0;
      crossings = 0;
      cur_row = 0;
      first = 1;
      held_height = 0;
      held_mat = 0;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function int pending();
      return expected_columns.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_VOXEL_SIZE:     voxel_size = longint'(data);
        CFG_BRUSH_MATERIAL: brush_material = longint'(data[MAT_W-1:0]);
        CFG_LOW_ROW:        low_row = longint'($signed(data));
        CFG_HIGH_ROW:       high_row = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [15:0] sd, logic [7:0] sm,
                              logic signed [15:0] bd, logic ce);
      longint edit_dist;
      longint depth;
      longint mat;
      longint row;
      longint span;
      longint t;
      longint v;
      longint h;
      logic signed [15:0] row16;
      bit solid;
      column_result_t r;
      edit_dist = sd;
      depth = bd;
      mat = sm;
      if (brush_material == 0) begin
        if (depth > edit_dist) edit_dist = depth;
      end else if (depth > 0) begin
        if (-depth < edit_dist) edit_dist = -depth;
        mat = brush_material;
      end
      solid = (edit_dist <= 0);
      if (first) begin
        row16 = 16'(low_row);
        row = row16;
        crossings = 0;
        held_height = 0;
        held_mat = mat;
      end else begin
        row16 = 16'(cur_row + 1);
        row = row16;
        if (solid != prev_solid) begin
          if (crossings == 0 && prev_solid) begin
            span = edit_dist - prev_dist;
            if (span <= 0) begin
              t = (64'sd1 << FRAC) / 2;
            end else begin
              t = (-prev_dist * (64'sd1 << FRAC)) / span;
              if (t < 0) t = 0;
              if (t > (64'sd1 << FRAC)) t = 64'sd1 << FRAC;
            end
            v = (cur_row * (64'sd1 << FRAC) + t) * voxel_size;
            held_height = sat32(v >>> FRAC);
            held_mat = prev_mat;
          end
          if (crossings < 2) crossings++;
        end
      end
      prev_dist = edit_dist;
      prev_mat = mat;
      prev_solid = solid;
      cur_row = row;
      first = ce;
      if (ce) begin
        h = held_height;
        if (crossings == 0) begin
          if (solid) h = sat32((high_row + 1) * voxel_size);
          else h = sat32(low_row * voxel_size);
        end
        r.single_valued = (crossings == 0) || (crossings == 1 && !solid);
        r.height = 32'(h);
        r.material = 8'(held_mat);
        r.crossings = 2'(crossings);
        expected_columns = {expected_columns, r};
      end
    endfunction

    function void check_column(logic sv, logic signed [31:0] h, logic [7:0] m,
                               logic [1:0] c);
      column_result_t e;
      if (expected_columns.size() == 0) begin
        $display("%0t unexpected result: single %0d height %0d material %0d crossings %0d",
                 $time, sv, h, m, c);
        errors++;
        return;
      end
      e = expected_columns.pop_front();
      if (sv !== e.single_valued) begin
        $display("%0t single_valued expected %0d actual %0d", $time, e.single_valued, sv);
        errors++;
      end
      if (h !== e.height) begin
        $display("%0t surface_height expected %0d actual %0d", $time, e.height, h);
        errors++;
      end
      if (m !== e.material) begin
        $display("%0t surface_material expected %0d actual %0d", $time, e.material, m);
        errors++;
      end
      if (c !== e.crossings) begin
        $display("%0t crossing_count expected %0d actual %0d", $time, e.crossings, c);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  csc_in_if  in_chan();
  csc_out_if out_chan();

  column_surface_classifier_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  column_tracker tracker = new();
  int sent = 0;
  bit in_calm = 0;
  bit out_calm = 0;

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [15:0] rand_dist(bit ground);
    int mag;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      7, 8, 9: mag = $urandom_range(1, 32767);
      default: mag = $urandom_range(1, 700);
    endcase
    if (ground) return 16'(1 - mag);
    return 16'(mag);
  endfunction

  function automatic logic signed [15:0] rand_depth();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6: return 16'(-int'($urandom_range(1, 2000)));
      default: return 16'($urandom_range(0, 600));
    endcase
  endfunction

  function automatic logic [15:0] pick_row();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 200)) - 100);
      3: return 16'($urandom);
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_voxel();
    case ($urandom_range(0, 4))
      0: return 16'd1;
      1: return 16'hffff;
      2: return 16'd256;
      3: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  function automatic logic [15:0] pick_brush();
    case ($urandom_range(0, 3))
      0, 1: return 16'(MAT_CARVE);
      2: return 16'd255;
      default: return 16'($urandom_range(1, 254));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic write_all(logic [15:0] vox, logic [15:0] brush, logic [15:0] lo,
                           logic [15:0] hi);
    write_reg(CFG_VOXEL_SIZE, vox);
    write_reg(CFG_BRUSH_MATERIAL, brush);
    write_reg(CFG_LOW_ROW, lo);
    write_reg(CFG_HIGH_ROW, hi);
  endtask

  task automatic send_sample(logic signed [15:0] d, logic [7:0] m, logic signed [15:0] b,
                             logic e);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.stored_distance <= d;
    in_chan.stored_material <= m;
    in_chan.brush_depth <= b;
    in_chan.column_end <= e;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    tracker.take_sample(d, m, b, e);
    sent++;
  endtask

  task automatic send_column(int len, bit noise);
    int surf;
    bit ground;
    in_calm = ($urandom_range(0, 4) == 0);
    surf = $urandom_range(0, len);
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        ground = $urandom_range(0, 1);
      end else begin
        ground = (i < surf);
        if ($urandom_range(0, 11) == 0) ground = !ground;
      end
      send_sample(rand_dist(ground), 8'($urandom_range(0, 255)), rand_depth(), i == len - 1);
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, with calm stretches
  initial begin
    int stall;
    stall = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        tracker.check_column(out_chan.single_valued, out_chan.surface_height,
                             out_chan.surface_material, out_chan.crossing_count);
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else begin
        out_chan.ready <= 1'b1;
        stall = pick_gap(out_calm);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle = 0;
      else idle++;
    end
    $display("column_surface_classifier_core: mismatch");
    $finish;
  end

  initial begin
    int phase;
    int phase_end;
    int len;
    int r;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_VOXEL_SIZE;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.stored_distance <= '0;
    in_chan.stored_material <= '0;
    in_chan.brush_depth <= '0;
    in_chan.column_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single ground sample, single air sample
    send_sample(-16'sd256, 8'd5, -16'sd32768, 1'b1);
    send_sample(16'sd32767, 8'd255, -16'sd1, 1'b1);
    // ground below air, interpolated
    send_sample(-16'sd128, 8'd7, -16'sd512, 1'b0);
    send_sample(16'sd128, 8'd9, -16'sd512, 1'b1);
    // air below ground, zero distance counts as ground
    send_sample(16'sd100, 8'd1, -16'sd100, 1'b0);
    send_sample(-16'sd100, 8'd2, -16'sd100, 1'b0);
    send_sample(16'sd0, 8'd3, -16'sd32768, 1'b1);
    // three crossings, count saturates
    send_sample(-16'sd32768, 8'd0, -16'sd32768, 1'b0);
    send_sample(16'sd32767, 8'd0, -16'sd1, 1'b0);
    send_sample(-16'sd5, 8'd0, -16'sd1, 1'b0);
    send_sample(16'sd5, 8'd0, -16'sd1, 1'b1);
    // carve
    send_sample(-16'sd300, 8'd4, 16'sd32767, 1'b0);
    send_sample(-16'sd300, 8'd4, -16'sd32768, 1'b1);
    settle();
    write_reg(CFG_BRUSH_MATERIAL, 16'd255);
    // add ground, most negative depth leaves the sample alone
    send_sample(16'sd200, 8'd3, 16'sd32767, 1'b0);
    send_sample(16'sd200, 8'd3, -16'sd32768, 1'b0);
    send_sample(16'sd0, 8'd3, 16'sd1, 1'b1);
    send_sample(16'sd32767, 8'd1, -16'sd32768, 1'b1);
    settle();

    phase = 0;
    while (sent < TOTAL_SAMPLES) begin
      if (phase == 0) write_all(16'hffff, 16'(MAT_CARVE), 16'h7fff, 16'h7fff);
      else if (phase == 1) write_all(16'd1, 16'd255, 16'h8000, 16'h8000);
      else write_all(pick_voxel(), pick_brush(), pick_row(), pick_row());
      phase_end = (sent + PHASE_SAMPLES < TOTAL_SAMPLES) ? sent + PHASE_SAMPLES
                                                         : TOTAL_SAMPLES;
      while (sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 50) len = $urandom_range(1, 6);
        else if (r < 90) len = $urandom_range(7, 20);
        else len = $urandom_range(21, 70);
        send_column(len, $urandom_range(0, 9) == 0);
      end
      settle();
      phase++;
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("column_surface_classifier_core: match");
    end else begin
      $display("column_surface_classifier_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/csc_pkg.sv
rtl/csc_if.sv
rtl/csc_fifo.sv
rtl/csc_front.sv
rtl/csc_back.sv
rtl/column_surface_classifier_core.sv
verif/tb_column_surface_classifier_core.sv
